/* rtl/pbs_pkg.sv */
`timescale 1ns / 1ps

package pbs_pkg;

    // Sizing
    localparam int MAX_BITS   = 16;
    localparam int NUM_GROUPS = MAX_BITS + 1;
    localparam int GRP_IDX_W  = $clog2(NUM_GROUPS);
    localparam int SLOT_W     = MAX_BITS + 1;
    localparam int STEP_W     = $clog2(MAX_BITS + 2);
    localparam int STATE_W    = 16;
    localparam int POS_W      = 16;
    localparam int CNT_W      = 5;
    localparam int NBITS_W    = 5;

    // Item kinds
    localparam logic KIND_PLACE   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_ROW,
        ST_SUM
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic                 place_en;
        logic                 walk_clear;
        logic                 row_add;
        logic                 sum_en;
        logic                 sum_incl;
        logic [GRP_IDX_W-1:0] sum_idx;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic                 out_free;
        logic [GRP_IDX_W-1:0] eff_n;
    } t_status;

endpackage

/* rtl/pbs_if.sv */
`timescale 1ns / 1ps

// Item channel
interface pbs_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [pbs_pkg::STATE_W-1:0] state_value;

    modport source (output valid, kind, state_value, input ready);
    modport sink   (input valid, kind, state_value, output ready);
endinterface

// Result channel
interface pbs_out_if;
    logic                      valid;
    logic                      ready;
    logic [pbs_pkg::POS_W-1:0] position;
    logic [pbs_pkg::CNT_W-1:0] particle_count;
    logic                      group_full;

    modport source (output valid, position, particle_count, group_full, input ready);
    modport sink   (input valid, position, particle_count, group_full, output ready);
endinterface

/* rtl/popcount_bucket_scatter_core.sv */
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// i_item    in   kind (0 place, 1 restart), state_value[15:0]
// o_result  out  position[15:0], particle_count[4:0], group_full
// i_cfg_*   in   num_bits[4:0], written when i_cfg_wr_en is high
//
// A place beat does popcount, group lookup and slot update in one pass, with the
// result held in an output register; a new place beat is taken each cycle while
// no restart runs and that register is free or being drained.
// A restart beat gives no result and holds ready low while the tables are rebuilt
// (Pascal rows 1..n, then a 17-step prefix walk over the group table).
// After reset the same walk runs for n = 16 before the first beat.

module popcount_bucket_scatter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [pbs_pkg::NBITS_W-1:0] i_cfg_wr_data,
    pbs_in_if.sink                      i_item,
    pbs_out_if.source                   o_result
);

    pbs_pkg::t_cmd    w_cmd;
    pbs_pkg::t_status w_status;

    // Sequencer
    pbs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .i_item_kind  (i_item.kind),
        .i_status     (w_status),
        .o_item_ready (i_item.ready),
        .o_cmd        (w_cmd)
    );

    // Tables, popcount and result register
    pbs_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_state_value    (i_item.state_value),
        .i_cmd            (w_cmd),
        .i_out_ready      (o_result.ready),
        .o_status         (w_status),
        .o_out_valid      (o_result.valid),
        .o_position       (o_result.position),
        .o_particle_count (o_result.particle_count),
        .o_group_full     (o_result.group_full)
    );

endmodule

/* rtl/pbs_ctrl.sv */
`timescale 1ns / 1ps

module pbs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  logic             i_item_kind,
    input  pbs_pkg::t_status i_status,
    output logic             o_item_ready,
    output pbs_pkg::t_cmd    o_cmd
);

    pbs_pkg::t_state                r_state, n_state;
    logic [pbs_pkg::STEP_W-1:0]     r_rebuild_step, n_rebuild_step;
    logic [pbs_pkg::GRP_IDX_W-1:0]  r_walk_n, n_walk_n;
    logic                           w_accept;

    // State registers; reset runs a rebuild for the full bit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= pbs_pkg::ST_START;
            r_rebuild_step <= '0;
            r_walk_n       <= pbs_pkg::GRP_IDX_W'(pbs_pkg::MAX_BITS);
        end else begin
            r_state        <= n_state;
            r_rebuild_step <= n_rebuild_step;
            r_walk_n       <= n_walk_n;
        end
    end

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        n_rebuild_step = r_rebuild_step;
        n_walk_n       = r_walk_n;
        o_cmd          = '0;
        o_item_ready   = 1'b0;
        w_accept       = 1'b0;
        case (r_state)
            pbs_pkg::ST_IDLE: begin
                o_item_ready = i_status.out_free;
                w_accept     = i_item_valid && i_status.out_free;
                if (w_accept) begin
                    if (i_item_kind == pbs_pkg::KIND_RESTART) begin
                        n_state  = pbs_pkg::ST_START;
                        n_walk_n = i_status.eff_n;
                    end else begin
                        o_cmd.place_en = 1'b1;
                    end
                end
            end
            pbs_pkg::ST_START: begin
                // row = {1,0,...}, accumulator = 0
                o_cmd.walk_clear = 1'b1;
                n_rebuild_step   = pbs_pkg::STEP_W'(1);
                n_state          = pbs_pkg::ST_ROW;
            end
            pbs_pkg::ST_ROW: begin
                // one Pascal row per cycle, rows 1..n
                if (r_rebuild_step > pbs_pkg::STEP_W'(r_walk_n)) begin
                    n_rebuild_step = '0;
                    n_state        = pbs_pkg::ST_SUM;
                end else begin
                    o_cmd.row_add  = 1'b1;
                    n_rebuild_step = r_rebuild_step + pbs_pkg::STEP_W'(1);
                end
            end
            pbs_pkg::ST_SUM: begin
                // prefix sum, one group per cycle
                o_cmd.sum_en   = 1'b1;
                o_cmd.sum_idx  = r_rebuild_step[pbs_pkg::GRP_IDX_W-1:0];
                o_cmd.sum_incl = (r_rebuild_step <= pbs_pkg::STEP_W'(r_walk_n));
                if (r_rebuild_step == pbs_pkg::STEP_W'(pbs_pkg::MAX_BITS)) begin
                    n_rebuild_step = '0;
                    n_state        = pbs_pkg::ST_IDLE;
                end else begin
                    n_rebuild_step = r_rebuild_step + pbs_pkg::STEP_W'(1);
                end
            end
            default: begin
                n_state        = pbs_pkg::ST_IDLE;
                n_rebuild_step = '0;
            end
        endcase
    end

endmodule

/* rtl/pbs_datapath.sv */
`timescale 1ns / 1ps

module pbs_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [pbs_pkg::NBITS_W-1:0]  i_cfg_wr_data,
    input  logic [pbs_pkg::STATE_W-1:0]  i_state_value,
    input  pbs_pkg::t_cmd                i_cmd,
    input  logic                         i_out_ready,
    output pbs_pkg::t_status             o_status,
    output logic                         o_out_valid,
    output logic [pbs_pkg::POS_W-1:0]    o_position,
    output logic [pbs_pkg::CNT_W-1:0]    o_particle_count,
    output logic                         o_group_full
);

    logic [pbs_pkg::NBITS_W-1:0]   r_num_bits;
    logic [pbs_pkg::SLOT_W-1:0]    r_next_slot [pbs_pkg::NUM_GROUPS];
    logic [pbs_pkg::SLOT_W-1:0]    r_end_slot  [pbs_pkg::NUM_GROUPS];
    logic [pbs_pkg::SLOT_W-1:0]    r_row       [pbs_pkg::NUM_GROUPS];
    logic [pbs_pkg::SLOT_W-1:0]    r_acc;
    logic                          r_out_valid;
    logic [pbs_pkg::POS_W-1:0]     r_position;
    logic [pbs_pkg::CNT_W-1:0]     r_count;
    logic                          r_full;

    logic [pbs_pkg::GRP_IDX_W-1:0] w_eff_n;
    logic [pbs_pkg::GRP_IDX_W-1:0] w_pop;
    logic [pbs_pkg::SLOT_W-1:0]    w_slot;
    logic                          w_full;
    logic [pbs_pkg::SLOT_W-1:0]    n_acc;

    // Bit count saturated to the table size
    assign w_eff_n = (r_num_bits > pbs_pkg::NBITS_W'(pbs_pkg::MAX_BITS))
                   ? pbs_pkg::GRP_IDX_W'(pbs_pkg::MAX_BITS)
                   : pbs_pkg::GRP_IDX_W'(r_num_bits);

    // Popcount of the low n state bits
    always_comb begin
        w_pop = '0;
        for (int i = 0; i < pbs_pkg::STATE_W; i++) begin
            if (pbs_pkg::GRP_IDX_W'(i) < w_eff_n) begin
                w_pop = w_pop + pbs_pkg::GRP_IDX_W'(i_state_value[i]);
            end
        end
    end

    // Group lookup and exhaustion check
    assign w_slot = r_next_slot[w_pop];
    assign w_full = (w_slot >= r_end_slot[w_pop]);

    // Prefix accumulator step
    assign n_acc = i_cmd.sum_incl ? (r_acc + r_row[i_cmd.sum_idx]) : r_acc;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bits <= pbs_pkg::NBITS_W'(pbs_pkg::MAX_BITS);
        end else if (i_cfg_wr_en) begin
            r_num_bits <= i_cfg_wr_data;
        end
    end

    // Pascal row and accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_clear) begin
            r_acc <= '0;
            for (int t = 0; t < pbs_pkg::NUM_GROUPS; t++) begin
                r_row[t] <= (t == 0) ? pbs_pkg::SLOT_W'(1) : '0;
            end
        end else if (i_cmd.row_add) begin
            for (int t = 1; t < pbs_pkg::NUM_GROUPS; t++) begin
                r_row[t] <= r_row[t] + r_row[t-1];
            end
        end else if (i_cmd.sum_en) begin
            r_acc <= n_acc;
        end
    end

    // Group slot tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_en) begin
            r_next_slot[i_cmd.sum_idx] <= r_acc;
            r_end_slot[i_cmd.sum_idx]  <= n_acc;
        end else if (i_cmd.place_en && !w_full) begin
            r_next_slot[w_pop] <= w_slot + pbs_pkg::SLOT_W'(1);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.place_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.place_en) begin
            r_position <= w_full ? '0 : pbs_pkg::POS_W'(w_slot);
            r_count    <= pbs_pkg::CNT_W'(w_pop);
            r_full     <= w_full;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.eff_n    = w_eff_n;
    assign o_out_valid       = r_out_valid;
    assign o_position        = r_position;
    assign o_particle_count  = r_count;
    assign o_group_full      = r_full;

endmodule
